### hdl/dda_line_rasterizer_macros.svh
// ----------------------------------------------------------------------------
// dda_line_rasterizer_macros.svh
// Assertion macros shared by the line rasterizer modules.
// ----------------------------------------------------------------------------
`ifndef DDA_LINE_RASTERIZER_MACROS_SVH
`define DDA_LINE_RASTERIZER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DDA_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("dda_line_rasterizer: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define DDA_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("dda_line_rasterizer: next-cycle check failed");

`endif

### hdl/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg
// Types and constants shared by the DDA line rasterizer modules.
// ----------------------------------------------------------------------------
package dda_pkg;

   localparam int COORD_BITS   = 11;
   localparam int FRAC_DEFAULT = 16;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   typedef struct packed {
      logic                  kind;
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [COORD_BITS-1:0] end_x;
      logic [COORD_BITS-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic                  last_pixel;
      logic                  pixel_valid;
   } rsp_type;

   // Classified command handed from front to back.
   typedef struct packed {
      logic                  kind;
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [COORD_BITS-1:0] mag_x;
      logic [COORD_BITS-1:0] mag_y;
      logic                  neg_x;
      logic                  neg_y;
      logic [COORD_BITS-1:0] len;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type data;
   } push_type;

   typedef struct packed {
      logic    valid;
      cmd_type data;
   } head_type;

endpackage

### hdl/dda_front.sv
// ----------------------------------------------------------------------------
// dda_front
// Accepts request items, derives line deltas and length, pushes commands.
// ----------------------------------------------------------------------------
module dda_front (
   input  logic              req_valid,
   output logic              req_ready,
   input  dda_pkg::req_type  req_data,
   input  logic              queue_full,
   output dda_pkg::push_type push_out
);

   localparam int CB = dda_pkg::COORD_BITS;

   logic signed [CB:0] dx;
   logic signed [CB:0] dy;
   logic [CB-1:0]      ax;
   logic [CB-1:0]      ay;

   always_comb begin
      dx = $signed({1'b0, req_data.end_x}) - $signed({1'b0, req_data.start_x});
      dy = $signed({1'b0, req_data.end_y}) - $signed({1'b0, req_data.start_y});
      ax = dx[CB] ? CB'(-dx) : dx[CB-1:0];
      ay = dy[CB] ? CB'(-dy) : dy[CB-1:0];
   end

   assign req_ready = !queue_full;

   always_comb begin
      push_out.push         = req_valid && !queue_full;
      push_out.data.kind    = req_data.kind;
      push_out.data.start_x = req_data.start_x;
      push_out.data.start_y = req_data.start_y;
      push_out.data.mag_x   = ax;
      push_out.data.mag_y   = ay;
      push_out.data.neg_x   = dx[CB];
      push_out.data.neg_y   = dy[CB];
      push_out.data.len     = (ax > ay) ? ax : ay;
   end

endmodule

### hdl/dda_queue.sv
// ----------------------------------------------------------------------------
// dda_queue
// Short first-word-fall-through command queue between front and back.
// ----------------------------------------------------------------------------
`include "dda_line_rasterizer_macros.svh"

module dda_queue (
   input  logic              clock,
   input  logic              reset,
   input  dda_pkg::push_type push_in,
   output logic              full,
   output dda_pkg::head_type head,
   input  logic              pop
);

   localparam int DEPTH = dda_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dda_pkg::cmd_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff,  count_in;
   logic              do_push;
   logic              do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.data  = entry_ff[rd_ptr_ff];
   assign do_push    = push_in.push && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_in.data;
      end
   end

   // Occupancy must track the pointer distance.
   `DDA_ASSERT_SAME(a_queue_count_ptrs, clock, reset,
      (count_ff == '0) || (count_ff == CNT_W'(DEPTH)),
      wr_ptr_ff == rd_ptr_ff)

endmodule

### hdl/dda_back.sv
// ----------------------------------------------------------------------------
// dda_back
// Executes commands: divides for the per-step increments, steps the
// fixed-point position and holds the result in an output register.
// ----------------------------------------------------------------------------
`include "dda_line_rasterizer_macros.svh"

module dda_back #(
   parameter int FRAC_BITS = dda_pkg::FRAC_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  dda_pkg::head_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dda_pkg::rsp_type  rsp_data
);

   localparam int CB     = dda_pkg::COORD_BITS;
   localparam int POS_W  = CB + FRAC_BITS + 1;
   localparam int STEP_W = FRAC_BITS + 2;
   localparam int Q_W    = FRAC_BITS + 1;
   localparam int R_W    = CB + 1;
   localparam int CNT_W  = $clog2(FRAC_BITS + 1);
   localparam logic [POS_W:0] HALF = (POS_W + 1)'(1) << (FRAC_BITS - 1);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_DIV  = 2'b10
   } back_state_type;

   back_state_type     state_ff, state_in;
   logic [POS_W-1:0]   pos_x_ff, pos_x_in;
   logic [POS_W-1:0]   pos_y_ff, pos_y_in;
   logic [STEP_W-1:0]  step_x_ff, step_x_in;
   logic [STEP_W-1:0]  step_y_ff, step_y_in;
   logic [CB-1:0]      steps_left_ff, steps_left_in;
   logic               line_active_ff, line_active_in;
   logic               rsp_valid_ff, rsp_valid_in;
   dda_pkg::rsp_type   rsp_ff, rsp_in;

   // Divider state
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [R_W-1:0]     rem_x_ff, rem_x_in;
   logic [R_W-1:0]     rem_y_ff, rem_y_in;
   logic [Q_W-1:0]     quo_x_ff, quo_x_in;
   logic [Q_W-1:0]     quo_y_ff, quo_y_in;
   logic [CB-1:0]      mag_x_ff, mag_x_in;
   logic [CB-1:0]      mag_y_ff, mag_y_in;
   logic [CB-1:0]      len_ff, len_in;
   logic               neg_x_ff, neg_x_in;
   logic               neg_y_ff, neg_y_in;

   logic               out_free;
   logic [R_W-1:0]     trial_x, trial_y;
   logic               ge_x, ge_y;
   logic [Q_W-1:0]     quo_x_next, quo_y_next;
   logic [POS_W-1:0]   pos_x_step, pos_y_step;
   logic [POS_W:0]     round_x, round_y;
   logic [CB-1:0]      pix_x, pix_y;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop       = (state_ff == S_IDLE) && head.valid && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // One restoring division bit per cycle for both axes; remainder stays below len.
   always_comb begin
      trial_x    = (cnt_ff == '0) ? {1'b0, mag_x_ff} : {rem_x_ff[R_W-2:0], 1'b0};
      trial_y    = (cnt_ff == '0) ? {1'b0, mag_y_ff} : {rem_y_ff[R_W-2:0], 1'b0};
      ge_x       = (trial_x >= {1'b0, len_ff});
      ge_y       = (trial_y >= {1'b0, len_ff});
      quo_x_next = {quo_x_ff[Q_W-2:0], ge_x};
      quo_y_next = {quo_y_ff[Q_W-2:0], ge_y};
   end

   // Advance position and round half up; clamp negative positions to zero.
   always_comb begin
      pos_x_step = pos_x_ff + {{(POS_W - STEP_W){step_x_ff[STEP_W-1]}}, step_x_ff};
      pos_y_step = pos_y_ff + {{(POS_W - STEP_W){step_y_ff[STEP_W-1]}}, step_y_ff};
      round_x    = {1'b0, pos_x_step} + HALF;
      round_y    = {1'b0, pos_y_step} + HALF;
      pix_x      = pos_x_step[POS_W-1] ? '0 : round_x[FRAC_BITS+CB-1:FRAC_BITS];
      pix_y      = pos_y_step[POS_W-1] ? '0 : round_y[FRAC_BITS+CB-1:FRAC_BITS];
   end

   always_comb begin
      state_in       = state_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      step_x_in      = step_x_ff;
      step_y_in      = step_y_ff;
      steps_left_in  = steps_left_ff;
      line_active_in = line_active_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_in         = rsp_ff;
      cnt_in         = cnt_ff;
      rem_x_in       = rem_x_ff;
      rem_y_in       = rem_y_ff;
      quo_x_in       = quo_x_ff;
      quo_y_in       = quo_y_ff;
      mag_x_in       = mag_x_ff;
      mag_y_in       = mag_y_ff;
      len_in         = len_ff;
      neg_x_in       = neg_x_ff;
      neg_y_in       = neg_y_ff;

      case (state_ff)
         S_IDLE: begin
            if (pop) begin
               rsp_valid_in = 1'b1;
               if (head.data.kind == dda_pkg::KIND_START) begin
                  pos_x_in           = {1'b0, head.data.start_x, {FRAC_BITS{1'b0}}};
                  pos_y_in           = {1'b0, head.data.start_y, {FRAC_BITS{1'b0}}};
                  steps_left_in      = head.data.len;
                  line_active_in     = (head.data.len != '0);
                  step_x_in          = '0;
                  step_y_in          = '0;
                  rsp_in.pixel_x     = head.data.start_x;
                  rsp_in.pixel_y     = head.data.start_y;
                  rsp_in.last_pixel  = (head.data.len == '0);
                  rsp_in.pixel_valid = 1'b1;
                  mag_x_in           = head.data.mag_x;
                  mag_y_in           = head.data.mag_y;
                  len_in             = head.data.len;
                  neg_x_in           = head.data.neg_x;
                  neg_y_in           = head.data.neg_y;
                  cnt_in             = '0;
                  quo_x_in           = '0;
                  quo_y_in           = '0;
                  if (head.data.len != '0) begin
                     state_in = S_DIV;
                  end
               end else if (!line_active_ff || steps_left_ff == '0) begin
                  line_active_in     = 1'b0;
                  rsp_in.pixel_x     = '0;
                  rsp_in.pixel_y     = '0;
                  rsp_in.last_pixel  = 1'b0;
                  rsp_in.pixel_valid = 1'b0;
               end else begin
                  pos_x_in           = pos_x_step;
                  pos_y_in           = pos_y_step;
                  steps_left_in      = steps_left_ff - 1'b1;
                  line_active_in     = (steps_left_ff != CB'(1));
                  rsp_in.pixel_x     = pix_x;
                  rsp_in.pixel_y     = pix_y;
                  rsp_in.last_pixel  = (steps_left_ff == CB'(1));
                  rsp_in.pixel_valid = 1'b1;
               end
            end
         end
         S_DIV: begin
            rem_x_in = ge_x ? trial_x - {1'b0, len_ff} : trial_x;
            rem_y_in = ge_y ? trial_y - {1'b0, len_ff} : trial_y;
            quo_x_in = quo_x_next;
            quo_y_in = quo_y_next;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(FRAC_BITS)) begin
               // Apply the sign after truncating the magnitude.
               step_x_in = neg_x_ff ? STEP_W'(-{1'b0, quo_x_next}) : {1'b0, quo_x_next};
               step_y_in = neg_y_ff ? STEP_W'(-{1'b0, quo_y_next}) : {1'b0, quo_y_next};
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         pos_x_ff       <= '0;
         pos_y_ff       <= '0;
         step_x_ff      <= '0;
         step_y_ff      <= '0;
         steps_left_ff  <= '0;
         line_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         cnt_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         pos_x_ff       <= pos_x_in;
         pos_y_ff       <= pos_y_in;
         step_x_ff      <= step_x_in;
         step_y_ff      <= step_y_in;
         steps_left_ff  <= steps_left_in;
         line_active_ff <= line_active_in;
         rsp_valid_ff   <= rsp_valid_in;
         cnt_ff         <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff   <= rsp_in;
      rem_x_ff <= rem_x_in;
      rem_y_ff <= rem_y_in;
      quo_x_ff <= quo_x_in;
      quo_y_ff <= quo_y_in;
      mag_x_ff <= mag_x_in;
      mag_y_ff <= mag_y_in;
      len_ff   <= len_in;
      neg_x_ff <= neg_x_in;
      neg_y_ff <= neg_y_in;
   end

   `DDA_ASSERT_SAME(a_no_pop_while_div, clock, reset,
      state_ff == S_DIV, !pop)
   `DDA_ASSERT_SAME(a_active_has_steps, clock, reset,
      line_active_ff && state_ff == S_IDLE, steps_left_ff != '0)
   `DDA_ASSERT_SAME(a_invalid_pixel_zero, clock, reset,
      rsp_valid_ff && !rsp_ff.pixel_valid,
      rsp_ff.pixel_x == '0 && rsp_ff.pixel_y == '0 && !rsp_ff.last_pixel)
   `DDA_ASSERT_NEXT(a_start_sets_last, clock, reset,
      pop && head.data.kind == dda_pkg::KIND_START && head.data.len == '0,
      rsp_valid_ff && rsp_ff.last_pixel && !line_active_ff)

endmodule

### hdl/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer: start items set up a line, step items emit pixels.
// ----------------------------------------------------------------------------
// Usage:
//   req_* channel (valid/ready) carries one item: kind 0 starts a line from
//   start_x/start_y to end_x/end_y, kind 1 advances one pixel.
//   rsp_* channel (valid/ready) returns exactly one result per item: the
//   rounded pixel, a last mark on the endpoint, and pixel_valid low for a
//   step with no active line.
//   An accepted item passes through the command queue and then the output
//   register while the back end is idle and the receiver keeps up; a step
//   accepted right behind a start waits for the divider.
//   Step items sustain one per cycle while the back end is not dividing and
//   the receiver keeps up. A start item with nonzero length holds the back
//   end while the bit-serial divider forms both increments; the start pixel
//   is already on rsp_* during that time.
//   A two-entry command queue lets the front keep accepting items while
//   the back end divides or the receiver stalls; a stalled result is held
//   in the output register.
//   Synchronous reset clears the queue, drops any active line and empties
//   the output register.
// ----------------------------------------------------------------------------
module dda_line_rasterizer #(
   parameter int FRAC_BITS = dda_pkg::FRAC_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dda_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dda_pkg::rsp_type rsp_data
);

   dda_pkg::push_type push;
   dda_pkg::head_type head;
   logic              queue_full;
   logic              pop;

   dda_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push_out   (push)
   );

   dda_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .full    (queue_full),
      .head    (head),
      .pop     (pop)
   );

   dda_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the DDA line rasterizer. Start and step items are
// sent with random gaps, every result is predicted in fixed point and
// compared field by field as the receiver drains it with random stalls.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CB          = dda_pkg::COORD_BITS;
   localparam int FRAC        = dda_pkg::FRAC_DEFAULT;
   localparam int POS_W       = 1 + CB + FRAC;
   localparam int INC_W       = FRAC + 2;
   localparam int COORD_MAX   = (1 << CB) - 1;
   localparam int ITEM_TARGET = 1275;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   dda_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   dda_pkg::rsp_type rsp_data;

   // predicted rasterizer state
   logic signed [POS_W-1:0]  pen_x, pen_y;
   logic signed [INC_W-1:0]  inc_x, inc_y;
   logic [CB-1:0]            pixels_left;
   logic                     line_open;

   dda_pkg::rsp_type pending_pixels[$];
   int      error_count = 0;
   int      items_sent  = 0;
   bit      throttle    = 1'b0;
   int      ready_hold  = 0;
   int      ready_gap;

   dda_line_rasterizer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Mostly no gap, some short ones, a few long ones.
   function automatic int draw_gap();
      int r;
      if (!throttle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int clamp_coord(input int v);
      if (v < 0) return 0;
      if (v > COORD_MAX) return COORD_MAX;
      return v;
   endfunction

   function automatic logic signed [INC_W-1:0] scaled_increment(input int d, input int len);
      int unsigned mag;
      int unsigned q;
      mag = (d < 0) ? -d : d;
      q = (mag << FRAC) / len;
      // truncate magnitude, then apply sign
      return (d < 0) ? INC_W'(-q) : INC_W'(q);
   endfunction

   function automatic logic [CB-1:0] round_half_up(input logic signed [POS_W-1:0] p);
      longint v;
      v = p;
      if (v < 0) return '0;
      v = (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
      return v[CB-1:0];
   endfunction

   function automatic dda_pkg::rsp_type next_pixel(input dda_pkg::req_type item);
      int               dx, dy, ax, ay, len;
      dda_pkg::rsp_type px;
      px = '0;
      if (item.kind == dda_pkg::KIND_START) begin
         dx = int'(item.end_x) - int'(item.start_x);
         dy = int'(item.end_y) - int'(item.start_y);
         ax = (dx < 0) ? -dx : dx;
         ay = (dy < 0) ? -dy : dy;
         len = (ax > ay) ? ax : ay;
         pen_x = '0;
         pen_y = '0;
         pen_x[FRAC +: CB] = item.start_x;
         pen_y[FRAC +: CB] = item.start_y;
         px.pixel_x = item.start_x;
         px.pixel_y = item.start_y;
         px.pixel_valid = 1'b1;
         if (len == 0) begin
            inc_x = '0;
            inc_y = '0;
            pixels_left = '0;
            line_open = 1'b0;
            px.last_pixel = 1'b1;
         end else begin
            inc_x = scaled_increment(dx, len);
            inc_y = scaled_increment(dy, len);
            pixels_left = len[CB-1:0];
            line_open = 1'b1;
         end
      end else if (!line_open || pixels_left == 0) begin
         line_open = 1'b0;
      end else begin
         pen_x = pen_x + inc_x;
         pen_y = pen_y + inc_y;
         pixels_left = pixels_left - 1'b1;
         px.pixel_x = round_half_up(pen_x);
         px.pixel_y = round_half_up(pen_y);
         px.last_pixel = (pixels_left == 0);
         px.pixel_valid = 1'b1;
         if (pixels_left == 0) line_open = 1'b0;
      end
      return px;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("ERROR @%0t: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // Send one item; predict its pixel at the transfer edge.
   task automatic send_item(input dda_pkg::req_type item);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      pending_pixels.insert(pending_pixels.size(), next_pixel(item));
      items_sent++;
   endtask

   task automatic send_step();
      dda_pkg::req_type item;
      item.kind    = dda_pkg::KIND_STEP;
      item.start_x = CB'($urandom);
      item.start_y = CB'($urandom);
      item.end_x   = CB'($urandom);
      item.end_y   = CB'($urandom);
      send_item(item);
   endtask

   task automatic run_line(input int sx, input int sy, input int ex, input int ey,
                           input int nsteps);
      dda_pkg::req_type item;
      item.kind    = dda_pkg::KIND_START;
      item.start_x = CB'(sx);
      item.start_y = CB'(sy);
      item.end_x   = CB'(ex);
      item.end_y   = CB'(ey);
      send_item(item);
      repeat (nsteps) send_step();
   endtask

   task automatic test_steps_without_line();
      throttle = 1'b0;
      send_step();
      send_item('{kind: dda_pkg::KIND_STEP, start_x: '1, start_y: '1, end_x: '1,
                  end_y: '1});
   endtask

   task automatic test_directed_lines();
      run_line(0, 0, COORD_MAX, COORD_MAX, 3);
      // abandon the active line with a new start
      run_line(COORD_MAX, 0, 0, COORD_MAX, 2);
      run_line(5, 5, 5, 5, 1);
      run_line(COORD_MAX, COORD_MAX, COORD_MAX - 3, COORD_MAX - 1, 4);
      run_line(100, 7, 97, 12, 5);
   endtask

   task automatic test_long_line();
      int sx, sy, ex, ey, len;
      throttle = 1'b1;
      sx = $urandom_range(0, 1000);
      ex = sx + $urandom_range(300, 500);
      len = ex - sx;
      sy = $urandom_range(0, COORD_MAX);
      ey = clamp_coord(sy + $urandom_range(0, 2 * len) - len);
      if ($urandom_range(0, 1))
         run_line(ex, ey, sx, sy, len);
      else
         run_line(sy, sx, ey, ex, len);
   endtask

   task automatic test_random_lines();
      int sx, sy, ex, ey, reach, len, nsteps, pick;
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 9) == 0) throttle = !throttle;
         sx = $urandom_range(0, COORD_MAX);
         sy = $urandom_range(0, COORD_MAX);
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            ex = sx;
            ey = sy;
         end else if (pick < 14) begin
            ex = $urandom_range(0, COORD_MAX);
            ey = $urandom_range(0, COORD_MAX);
         end else begin
            reach = $urandom_range(1, 24);
            ex = clamp_coord(sx + $urandom_range(0, 2 * reach) - reach);
            ey = clamp_coord(sy + $urandom_range(0, 2 * reach) - reach);
         end
         len = (ex > sx) ? ex - sx : sx - ex;
         if (((ey > sy) ? ey - sy : sy - ey) > len) len = (ey > sy) ? ey - sy : sy - ey;
         pick = $urandom_range(0, 99);
         if (len > 60)
            nsteps = $urandom_range(0, 40);
         else if (pick < 15)
            nsteps = $urandom_range(0, len);
         else if (pick < 40)
            nsteps = len + $urandom_range(1, 3);
         else
            nsteps = len;
         run_line(sx, sy, ex, ey, nsteps);
      end
   endtask

   // receiver: random stalls
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         ready_gap = draw_gap();
         if (ready_gap == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready  <= 1'b0;
            ready_hold <= ready_gap - 1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("result transfer with no pixel expected");
         end else begin
            check_field("pixel_x", 16'(rsp_data.pixel_x),
                        16'(pending_pixels[0].pixel_x));
            check_field("pixel_y", 16'(rsp_data.pixel_y),
                        16'(pending_pixels[0].pixel_y));
            check_field("last_pixel", 16'(rsp_data.last_pixel),
                        16'(pending_pixels[0].last_pixel));
            check_field("pixel_valid", 16'(rsp_data.pixel_valid),
                        16'(pending_pixels[0].pixel_valid));
            void'(pending_pixels.pop_front());
         end
      end
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      rsp_ready <= 1'b0;
      pen_x = '0;
      pen_y = '0;
      inc_x = '0;
      inc_y = '0;
      pixels_left = '0;
      line_open = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_steps_without_line();
      test_directed_lines();
      test_long_line();
      test_random_lines();

      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
